// ----- sv/sgdl_pkg.sv -----
// shared types and constants for the stress-layout edge update block
`timescale 1ns / 1ps
package sgdl_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int POS_W     = 32;
  localparam int STEP_RST  = 8192;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_EDGE = 2'd1,
    ACT_READ = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_COINCIDE = 2'd1,
    STAT_SAME     = 2'd2,
    STAT_RSVD     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_SQRT = 2'd1,
    OP_DIV  = 2'd2,
    OP_NONE = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [40:0] opa;
    logic [32:0] opb;
    logic [63:0] rad;  // radicand, or numerator left-aligned in the top 57 bits
    logic [43:0] den;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_A, ST_CAP_A, ST_CAP_B, ST_CHK, ST_SQ_X, ST_SQ_Y, ST_ROOT,
    ST_DSQ, ST_DIV_R, ST_MUL_G, ST_DIV_G, ST_MV_X, ST_MV_Y, ST_WR_A, ST_WR_B,
    ST_RESP
  } state_t;

  function automatic logic [POS_W-1:0] clamp42(input logic signed [41:0] v);
    logic [POS_W-1:0] r;
    if (v > 42'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -42'sd2147483648) r = 32'h8000_0000;
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

// ----- sv/sgdl_ram.sv -----
// generic single-port ram with registered read
`timescale 1ns / 1ps
module sgdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- sv/sgdl_alu.sv -----
// shared arithmetic unit: registered multiply, bit-serial divide and square root
`timescale 1ns / 1ps
module sgdl_alu import sgdl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);
  logic        busy_r, done_r;
  alu_op_t     op_r;
  logic [5:0]  cnt_r;
  logic [63:0] nb_r, res_r;
  logic [45:0] rem_r, rem_nxt, sh, trial;
  logic [56:0] q_r, q_nxt;
  logic [43:0] den_r;
  logic [73:0] prod;
  logic        ge;

  assign prod = req.opa * req.opb;

  always_comb begin
    if (op_r == OP_SQRT) begin
      sh    = {rem_r[43:0], nb_r[63:62]};
      trial = {q_r[43:0], 2'b01};
    end else begin
      sh    = {rem_r[44:0], nb_r[63]};
      trial = {2'b00, den_r};
    end
    ge      = (sh >= trial);
    rem_nxt = ge ? (sh - trial) : sh;
    q_nxt   = {q_r[55:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.op == OP_MUL) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      nb_r  <= req.rad;
      den_r <= req.den;
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= (req.op == OP_SQRT) ? 6'd31 : 6'd56;
      if (req.op == OP_MUL) begin
        res_r <= prod[63:0];
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      nb_r  <= (op_r == OP_SQRT) ? {nb_r[61:0], 2'b00} : {nb_r[62:0], 1'b0};
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        res_r <= {7'd0, q_nxt};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !busy_r)
    else $error("alu started while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == 6'd0 && !req.start) |=> done_r)
    else $error("alu iteration ended without done");
endmodule

// ----- sv/sgd_graph_layout_edge_update.sv -----
// top level of the stress-layout edge update block
// Holds 1024 node positions (x, y signed Q16.16) in two single-port rams.
// Input stream: in_tuser carries the action (load, edge update, read, no-op),
// in_tdata the node indices, target distance and load coordinates.
// Each request gives exactly one result on the output stream: read_x and
// read_y in out_tdata (zero except on read) and a status code in out_tuser.
// The block takes one request at a time; in_tready is high only while idle.
// Load, no-op and an edge on a single node go straight to the response; read
// passes through the position read states first. An edge update runs on the
// shared arithmetic unit: a 32-step square root, two 57-step restoring
// divisions and six multiplies, sequenced by the state machine.
// Coincident endpoints finish after the position reads.
// Reset clears control state and sets the step size to 2.0; the position
// store is undefined until loaded. A result waits in the output register
// while out_tready is low, and the block holds the next result until the
// previous one is taken. step_size is written over the apb port at address 0.
`timescale 1ns / 1ps
module sgd_graph_layout_edge_update import sgdl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // node_a, node_b, target_distance, load_x, load_y
  input  logic [1:0]   in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // read_x, read_y
  output logic [1:0]   out_tuser,  // status
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  state_t state_r, state_nxt;

  logic [15:0]       step_r;
  action_t           act_r;
  logic [NODE_W-1:0] a_r, b_r, ram_addr;
  logic [15:0]       d_r, d_eff;
  logic [POS_W-1:0]  xa_r, ya_r, xb_r, yb_r, res_x_r, res_y_r;
  logic [POS_W-1:0]  ram_wx, ram_wy, ram_rx, ram_ry;
  logic signed [32:0] dx_r, dy_r;
  logic [32:0]       ux, uy, dist_r, dist_c, nm;
  logic [31:0]       sx, sy, dq, gq_r;
  logic              k, rneg_r, ram_we, wait_r;
  logic [1:0]        stat_r;
  logic [63:0]       sq_r;
  logic [43:0]       den_r;
  logic [40:0]       rq_r;
  logic [56:0]       gp_r;
  logic [39:0]       mx_r, my_r;
  logic signed [41:0] dlx, dly;
  logic              out_valid_r;
  logic [63:0]       out_data_r;
  logic [1:0]        out_user_r;
  logic              in_acc, alu_state;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign in_acc = in_tvalid && in_tready;
  assign d_eff  = (d_r == 16'd0) ? 16'd1 : d_r;

  assign ux = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign uy = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign k  = ux[32] | ux[31] | uy[32] | uy[31];
  assign sx = k ? ux[32:1] : ux[31:0];
  assign sy = k ? uy[32:1] : uy[31:0];
  assign dq = {d_eff, 16'd0};
  assign nm = rneg_r ? ({1'b0, dq} - dist_r) : (dist_r - {1'b0, dq});

  // config
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {16'd0, step_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 16'(STEP_RST);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == 3'd0) begin
      step_r <= cfg_pwdata[15:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (action_t'(in_tuser))
            ACT_READ: state_nxt = ST_RD_A;
            ACT_EDGE: state_nxt = (in_tdata[9:0] == in_tdata[19:10]) ? ST_RESP : ST_RD_A;
            default:  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_RD_A:  state_nxt = ST_CAP_A;
      ST_CAP_A: state_nxt = (act_r == ACT_READ) ? ST_RESP : ST_CAP_B;
      ST_CAP_B: state_nxt = ST_CHK;
      ST_CHK:   state_nxt = (dx_r == 33'sd0 && dy_r == 33'sd0) ? ST_RESP : ST_SQ_X;
      ST_SQ_X:  if (alu_rsp.done) state_nxt = ST_SQ_Y;
      ST_SQ_Y:  if (alu_rsp.done) state_nxt = ST_ROOT;
      ST_ROOT:  if (alu_rsp.done) state_nxt = ST_DSQ;
      ST_DSQ:   if (alu_rsp.done) state_nxt = ST_DIV_R;
      ST_DIV_R: if (alu_rsp.done) state_nxt = ST_MUL_G;
      ST_MUL_G: if (alu_rsp.done) state_nxt = ST_DIV_G;
      ST_DIV_G: if (alu_rsp.done) state_nxt = ST_MV_X;
      ST_MV_X:  if (alu_rsp.done) state_nxt = ST_MV_Y;
      ST_MV_Y:  if (alu_rsp.done) state_nxt = ST_WR_A;
      ST_WR_A:  state_nxt = ST_WR_B;
      ST_WR_B:  state_nxt = ST_RESP;
      ST_RESP:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    alu_state = 1'b0;
    alu_req   = '0;
    alu_req.op = OP_NONE;
    ram_we    = 1'b0;
    ram_addr  = a_r;
    ram_wx    = in_tdata[67:36];
    ram_wy    = in_tdata[99:68];
    case (state_r)
      ST_IDLE: begin
        ram_addr = in_tdata[9:0];
        ram_we   = in_acc && (action_t'(in_tuser) == ACT_LOAD);
      end
      ST_CAP_A: ram_addr = b_r;
      ST_SQ_X: begin
        alu_state   = 1'b1;
        alu_req.op  = OP_MUL;
        alu_req.opa = {9'd0, sx};
        alu_req.opb = {1'b0, sx};
      end
      ST_SQ_Y: begin
        alu_state   = 1'b1;
        alu_req.op  = OP_MUL;
        alu_req.opa = {9'd0, sy};
        alu_req.opb = {1'b0, sy};
      end
      ST_ROOT: begin
        alu_state   = 1'b1;
        alu_req.op  = OP_SQRT;
        alu_req.rad = sq_r;
      end
      ST_DSQ: begin
        alu_state   = 1'b1;
        alu_req.op  = OP_MUL;
        alu_req.opa = {25'd0, d_eff};
        alu_req.opb = {17'd0, d_eff};
      end
      ST_DIV_R: begin
        alu_state   = 1'b1;
        alu_req.op  = OP_DIV;
        alu_req.rad = {1'b0, nm, 30'd0};
        alu_req.den = {11'd0, dist_r};
      end
      ST_MUL_G: begin
        alu_state   = 1'b1;
        alu_req.op  = OP_MUL;
        alu_req.opa = rq_r;
        alu_req.opb = {17'd0, step_r};
      end
      ST_DIV_G: begin
        alu_state   = 1'b1;
        alu_req.op  = OP_DIV;
        alu_req.rad = {gp_r, 7'd0};
        alu_req.den = den_r;
      end
      ST_MV_X: begin
        alu_state   = 1'b1;
        alu_req.op  = OP_MUL;
        alu_req.opa = {8'd0, ux};
        alu_req.opb = {1'b0, gq_r};
      end
      ST_MV_Y: begin
        alu_state   = 1'b1;
        alu_req.op  = OP_MUL;
        alu_req.opa = {8'd0, uy};
        alu_req.opb = {1'b0, gq_r};
      end
      ST_WR_A: begin
        ram_we = 1'b1;
        ram_wx = clamp42(42'(signed'(xa_r)) - dlx);
        ram_wy = clamp42(42'(signed'(ya_r)) - dly);
      end
      ST_WR_B: begin
        ram_we   = 1'b1;
        ram_addr = b_r;
        ram_wx   = clamp42(42'(signed'(xb_r)) + dlx);
        ram_wy   = clamp42(42'(signed'(yb_r)) + dly);
      end
      default: ;
    endcase
    alu_req.start = alu_state && !wait_r;
  end

  // signed moves: the nodes move toward each other when they are too far apart
  assign dlx = (dx_r[32] != rneg_r) ? -42'(signed'({2'b00, mx_r})) : 42'(signed'({2'b00, mx_r}));
  assign dly = (dy_r[32] != rneg_r) ? -42'(signed'({2'b00, my_r})) : 42'(signed'({2'b00, my_r}));

  assign dist_c = k ? {alu_rsp.res[31:0], 1'b0} : {1'b0, alu_rsp.res[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (alu_req.start) wait_r <= 1'b1;
      else if (alu_rsp.done) wait_r <= 1'b0;
      if (state_r == ST_RESP && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= action_t'(in_tuser);
      a_r     <= in_tdata[9:0];
      b_r     <= in_tdata[19:10];
      d_r     <= in_tdata[35:20];
      res_x_r <= '0;
      res_y_r <= '0;
      stat_r  <= (action_t'(in_tuser) == ACT_EDGE && in_tdata[9:0] == in_tdata[19:10])
                 ? STAT_SAME : STAT_DONE;
    end
    case (state_r)
      ST_CAP_A: begin
        if (act_r == ACT_READ) begin
          res_x_r <= ram_rx;
          res_y_r <= ram_ry;
        end
        xa_r <= ram_rx;
        ya_r <= ram_ry;
      end
      ST_CAP_B: begin
        xb_r <= ram_rx;
        yb_r <= ram_ry;
        dx_r <= 33'(signed'(xa_r)) - 33'(signed'(ram_rx));
        dy_r <= 33'(signed'(ya_r)) - 33'(signed'(ram_ry));
      end
      ST_CHK: if (dx_r == 33'sd0 && dy_r == 33'sd0) stat_r <= STAT_COINCIDE;
      ST_SQ_X: if (alu_rsp.done) sq_r <= alu_rsp.res;
      ST_SQ_Y: if (alu_rsp.done) sq_r <= sq_r + alu_rsp.res;
      ST_ROOT: if (alu_rsp.done) begin
        dist_r <= (dist_c == 33'd0) ? 33'd1 : dist_c;
        rneg_r <= ((dist_c == 33'd0) ? 33'd1 : dist_c) < {1'b0, dq};
      end
      ST_DSQ: if (alu_rsp.done) den_r <= {alu_rsp.res[31:0], 12'd0};
      ST_DIV_R: if (alu_rsp.done) begin
        rq_r <= (alu_rsp.res > 64'h100_0000_0000) ? 41'h100_0000_0000 : alu_rsp.res[40:0];
      end
      ST_MUL_G: if (alu_rsp.done) gp_r <= alu_rsp.res[56:0];
      ST_DIV_G: if (alu_rsp.done) begin
        gq_r <= (alu_rsp.res > 64'h8000_0000) ? 32'h8000_0000 : alu_rsp.res[31:0];
      end
      ST_MV_X: if (alu_rsp.done) mx_r <= alu_rsp.res[63:24];
      ST_MV_Y: if (alu_rsp.done) my_r <= alu_rsp.res[63:24];
      default: ;
    endcase
    if (state_r == ST_RESP && (!out_valid_r || out_tready)) begin
      out_data_r <= {res_y_r, res_x_r};
      out_user_r <= stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  sgdl_ram #(.WIDTH(POS_W), .DEPTH(MAX_NODES)) u_ram_x (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wx), .rdata(ram_rx)
  );

  sgdl_ram #(.WIDTH(POS_W), .DEPTH(MAX_NODES)) u_ram_y (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wy), .rdata(ram_ry)
  );

  sgdl_alu u_alu (
    .clk(clk), .rst_n(rst_n), .req(alu_req), .rsp(alu_rsp)
  );

  assert property (@(posedge clk) disable iff (!rst_n) in_acc |=> state_r != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE || state_r == ST_WR_A || state_r == ST_WR_B))
    else $error("position store written outside load or write-back");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != STAT_DONE) |-> out_tdata == 64'd0)
    else $error("skipped update returned nonzero coordinates");
  assert property (@(posedge clk) disable iff (!rst_n) alu_rsp.done |-> wait_r)
    else $error("alu result with no operation pending");
endmodule
